// ===== src/salfc_pkg.sv =====
// ----------------------------------------------------------------------------
// salfc_pkg
// Shared types and constants for the size-aware LRU/FIFO cache policy.
// ----------------------------------------------------------------------------
package salfc_pkg;

  localparam int unsigned IdW    = 32;
  localparam int unsigned SizeW  = 32;
  localparam int unsigned BytesW = 40;
  localparam int unsigned EvCntW = 7;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [CfgIdxW-1:0] CfgCapacity = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgPolicy   = 8'd1;

  localparam logic OpRequest = 1'b0;
  localparam logic OpEvict   = 1'b1;

  localparam logic PolicyLru  = 1'b0;
  localparam logic PolicyFifo = 1'b1;

  typedef enum logic [1:0] {
    CellHold   = 2'd0,
    CellRemove = 2'd1,  // cells at or above pos take their upper neighbour
    CellPush   = 2'd2   // cells at or below pos take their lower neighbour
  } cell_op_e;

  typedef struct packed {
    logic             valid;
    logic [IdW-1:0]   id;
    logic [SizeW-1:0] size;
  } entry_t;

  typedef struct packed {
    cell_op_e       op;
    logic [IdW-1:0] lookup_id;
  } cell_cmd_t;

endpackage

// ===== src/salfc_cell.sv =====
// ----------------------------------------------------------------------------
// salfc_cell
// One place of the recency list: holds one entry, flags an id match and
// shifts towards either neighbour on command.
// ----------------------------------------------------------------------------
module salfc_cell
  import salfc_pkg::*;
#(
  parameter int unsigned PosW = 6,
  parameter int unsigned Idx  = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cell_cmd_t       cmd_i,
  input  logic [PosW-1:0] pos_i,
  input  entry_t          lower_i,
  input  entry_t          upper_i,
  output entry_t          entry_o,
  output logic            hit_o
);

  localparam logic [PosW-1:0] MyPos = PosW'(Idx);

  logic             valid_q, valid_d;
  logic [IdW-1:0]   id_q, id_d;
  logic [SizeW-1:0] size_q, size_d;

  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    size_d  = size_q;
    unique case (cmd_i.op)
      CellRemove: begin
        if (MyPos >= pos_i) begin
          valid_d = upper_i.valid;
          id_d    = upper_i.id;
          size_d  = upper_i.size;
        end
      end
      CellPush: begin
        if (MyPos <= pos_i) begin
          valid_d = lower_i.valid;
          id_d    = lower_i.id;
          size_d  = lower_i.size;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    size_q <= size_d;
  end

  assign entry_o = '{valid: valid_q, id: id_q, size: size_q};
  assign hit_o   = valid_q && (id_q == cmd_i.lookup_id);

endmodule

// ===== src/size_aware_lru_fifo_cache.sv =====
// ----------------------------------------------------------------------------
// size_aware_lru_fifo_cache
// Byte-capacity replacement policy over variable-size objects.
// ----------------------------------------------------------------------------
// Entries sit in a chain of cells kept in recency order: cell 0 is the most
// recent, the last valid cell the eviction victim, valid cells always packed
// from cell 0. An item passes the transfer, then the lookup (all cells
// compare the id in parallel, then the chain shifts to remove, refresh in
// LRU mode, or drop a stale entry), then on an admitted miss the tail
// evictions and the insert, and last the load of the output register,
// which waits while the output stalls. The input stalls until an item is done.
// Eviction, one entry per cycle, sets the worst case.
// ----------------------------------------------------------------------------
module size_aware_lru_fifo_cache
  import salfc_pkg::*;
#(
  parameter int unsigned ENTRIES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [BytesW-1:0]  cfg_data_i,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               operation_i,
  input  logic [IdW-1:0]     object_id_i,
  input  logic [SizeW-1:0]   object_size_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               found_o,
  output logic               admitted_o,
  output logic [EvCntW-1:0]  evicted_count_o,
  output logic [BytesW-1:0]  used_bytes_o
);

  localparam int unsigned PosW = $clog2(ENTRIES);
  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam logic [CntW-1:0] Full    = CntW'(ENTRIES);
  localparam logic [PosW-1:0] LastPos = PosW'(ENTRIES - 1);

  typedef enum logic [2:0] {
    StIdle, StLook, StEvict, StDone
  } state_e;

  state_e             state_q;
  logic [BytesW-1:0]  cap_q;
  logic               mode_q;
  logic               op_q;
  logic [IdW-1:0]     id_q;
  logic [SizeW-1:0]   size_q;
  logic [BytesW-1:0]  occ_q, occ_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [EvCntW-1:0]  ev_q;
  logic               found_q, adm_q;
  logic               out_valid_q, out_found_q, out_adm_q;
  logic [EvCntW-1:0]  out_ev_q;
  logic [BytesW-1:0]  out_used_q;

  cell_cmd_t          cmd;
  logic [PosW-1:0]    pos;
  entry_t             ent   [ENTRIES];
  entry_t             lower [ENTRIES];
  entry_t             upper [ENTRIES];
  logic [ENTRIES-1:0] hit;

  logic [PosW-1:0]    hit_pos;
  logic [SizeW-1:0]   hit_size;
  logic [SizeW-1:0]   tail_size;
  logic [PosW-1:0]    tail_pos;
  logic               hit_any;
  logic               need_room;
  logic               in_xfer, out_xfer;
  logic               out_load;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_q && !out_stall_i;
  assign out_load = (state_q == StDone) && (!out_valid_q || !out_stall_i);
  assign tail_pos = PosW'(cnt_q - CntW'(1));

  // the chain of cells; ids are unique in the store, so the match is one-hot
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign lower[g] = '{valid: 1'b1, id: id_q, size: size_q};
    end else begin : g_mid
      assign lower[g] = ent[g-1];
    end
    if (g == ENTRIES - 1) begin : g_tail
      assign upper[g] = '{valid: 1'b0, id: '0, size: '0};
    end else begin : g_up
      assign upper[g] = ent[g+1];
    end
    salfc_cell #(.PosW(PosW), .Idx(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .pos_i   (pos),
      .lower_i (lower[g]),
      .upper_i (upper[g]),
      .entry_o (ent[g]),
      .hit_o   (hit[g])
    );
  end

  always_comb begin
    hit_pos   = '0;
    hit_size  = '0;
    tail_size = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit[i]) begin
        hit_pos  = hit_pos | PosW'(i);
        hit_size = hit_size | ent[i].size;
      end
      if (PosW'(i) == tail_pos) begin
        tail_size = tail_size | ent[i].size;
      end
    end
  end

  assign hit_any   = |hit;
  // one extra bit so the fit test cannot wrap
  assign need_room = (cnt_q != '0) &&
                     ((({1'b0, occ_q} + (BytesW+1)'(size_q)) > {1'b0, cap_q}) ||
                      (cnt_q == Full));

  // chain command for the current state
  always_comb begin
    cmd.op        = CellHold;
    cmd.lookup_id = id_q;
    pos           = '0;
    occ_d         = occ_q;
    cnt_d         = cnt_q;
    unique case (state_q)
      StLook: begin
        if (hit_any) begin
          if (op_q == OpRequest && hit_size == size_q) begin
            if (mode_q == PolicyLru) begin
              cmd.op = CellPush;
              pos    = hit_pos;
            end
          end else begin
            // evict operation, or stale entry of another size
            cmd.op = CellRemove;
            pos    = hit_pos;
            occ_d  = (occ_q >= BytesW'(hit_size)) ? occ_q - BytesW'(hit_size) : '0;
            cnt_d  = cnt_q - CntW'(1);
          end
        end
      end
      StEvict: begin
        if (need_room) begin
          cmd.op = CellRemove;
          pos    = tail_pos;
          occ_d  = (occ_q >= BytesW'(tail_size)) ? occ_q - BytesW'(tail_size) : '0;
          cnt_d  = cnt_q - CntW'(1);
        end else begin
          cmd.op = CellPush;
          pos    = LastPos;
          occ_d  = occ_q + BytesW'(size_q);
          cnt_d  = cnt_q + CntW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cap_q       <= BytesW'(1048576);
      mode_q      <= PolicyLru;
      occ_q       <= '0;
      cnt_q       <= '0;
      ev_q        <= '0;
      found_q     <= 1'b0;
      adm_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgCapacity: cap_q  <= cfg_data_i;
          CfgPolicy:   mode_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_xfer) begin
            found_q <= 1'b0;
            adm_q   <= 1'b0;
            ev_q    <= '0;
            state_q <= StLook;
          end
        end
        StLook: begin
          if (hit_any && (op_q == OpEvict || hit_size == size_q)) begin
            found_q <= 1'b1;
            state_q <= StDone;
          end else if (op_q == OpRequest && BytesW'(size_q) < cap_q) begin
            state_q <= StEvict;
          end else begin
            state_q <= StDone;
          end
        end
        StEvict: begin
          if (need_room) begin
            ev_q <= ev_q + EvCntW'(1);
          end else begin
            adm_q   <= 1'b1;
            state_q <= StDone;
          end
        end
        StDone: begin
          if (out_load) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q   <= operation_i;
      id_q   <= object_id_i;
      size_q <= object_size_i;
    end
    if (out_load) begin
      out_found_q <= found_q;
      out_adm_q   <= adm_q;
      out_ev_q    <= ev_q;
      out_used_q  <= occ_q;
    end
  end

  assign in_stall_o      = (state_q != StIdle);
  assign out_valid_o     = out_valid_q;
  assign found_o         = out_found_q;
  assign admitted_o      = out_adm_q;
  assign evicted_count_o = out_ev_q;
  assign used_bytes_o    = out_used_q;

  // entry count never exceeds the chain length
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= Full)
    else $error("entry count above capacity of the chain");

  // an empty cache holds no bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni) (cnt_q == '0) |-> (occ_q == '0))
    else $error("bytes held with no entries");

  // a hit is never also an admission
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_q |-> !(out_found_q && out_adm_q))
    else $error("result both found and admitted");

  // a push into the chain always has a free cell at the tail
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == StEvict && !need_room) |-> (cnt_q != Full))
    else $error("insert into a full chain");

endmodule
